FILE: rtl/mef_pkg.sv
package mef_pkg;

  // Neighbor-kind codes of one cell
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_NORTH = 2'd1,
    KIND_SOUTH = 2'd2,
    KIND_BOTH  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CELL_SIZE     = 2'd0,
    CFG_INV_CELL_SIZE = 2'd1,
    CFG_INV_MANNING   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // Largest slope magnitude
  localparam logic [30:0] MAG31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] head_center;
    logic signed [31:0] head_east;
    logic signed [31:0] bed_center;
    logic signed [31:0] bed_east;
    logic signed [31:0] head_north;
    logic signed [31:0] head_south;
    logic signed [31:0] head_north_east;
    logic signed [31:0] head_south_east;
    kind_e              kind_center;
    kind_e              kind_east;
  } in_t;

  typedef struct packed {
    logic signed [31:0] flow;
    logic [31:0]        speed;
  } out_t;

endpackage

FILE: rtl/manning_edge_flux_core.sv
// Manning diffusive-wave flux across one grid edge.
// Input channel: in_valid_i / in_stall_o carry one edge (heads, beds, side
// heads, neighbor kinds). Output channel: out_valid_o / out_stall_i carry the
// edge discharge (flow) and the speed magnitude. Exactly one result per edge,
// in input order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 cell size, 1 inverse cell size, 2 inverse Manning n); other indexes are
// ignored. Write only while no edge is in flight.
// Throughput: one edge per cycle while no result waits on out_stall_i.
// Pipeline stages: front end 4, slope square root 32, root of slope (33+F)/2,
// ratio divider F+1, depth^(2/3) cube root 1+(66+F)/3, five scaled multiplies
// of 2 each, output register 1.
// Reset: pipeline empties, registers return to 1.0, 1.0 and 33.0.
// Stall: while a result waits with out_stall_i high the whole pipeline holds
// and in_stall_o is high; nothing is dropped or repeated.
module manning_edge_flux_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mef_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mef_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mef_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mef_pkg::CFG_W-1:0]         cfg_data_i
);
  import mef_pkg::*;

  localparam int unsigned RIN = 32 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int unsigned RW  = RIN / 2;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned CW  = (64 + FRAC_BITS + 2) / 3;
  localparam logic [31:0] ONE_RST = 32'(1) << FRAC_BITS;
  localparam logic [31:0] IMN_RST = 32'(33) << FRAC_BITS;

  // configuration registers
  logic [31:0] cell_size_q, inv_cell_size_q, inv_manning_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q     <= ONE_RST;
      inv_cell_size_q <= ONE_RST;
      inv_manning_q   <= IMN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_SIZE:     cell_size_q     <= cfg_data_i;
        CFG_INV_CELL_SIZE: inv_cell_size_q <= cfg_data_i;
        CFG_INV_MANNING:   inv_manning_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the result is stalled
  logic en;
  logic out_vld_q;
  out_t out_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // front end
  logic        f_vld, f_zero, f_pos;
  logic [30:0] f_ax;
  logic [31:0] f_depth;
  logic [62:0] f_ss;

  mef_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .data_i(in_data_i),
    .inv_cell_size_i(inv_cell_size_q),
    .valid_o(f_vld), .zero_o(f_zero), .pos_o(f_pos), .ax_o(f_ax),
    .depth_o(f_depth), .sumsq_o(f_ss)
  );

  // slope = sqrt(ax^2 + ay^2)
  localparam int unsigned SW1 = 65;
  logic           r1_vld;
  logic [31:0]    r1_slope;
  logic [SW1-1:0] r1_side;
  logic           r1_zero, r1_pos;
  logic [30:0]    r1_ax;
  logic [31:0]    r1_depth;

  mef_sqrt #(.NW(64), .SW(SW1)) u_sqrt_slope (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_vld), .rad_i({1'b0, f_ss}),
    .side_i({f_zero, f_pos, f_ax, f_depth}),
    .valid_o(r1_vld), .root_o(r1_slope), .side_o(r1_side)
  );
  assign {r1_zero, r1_pos, r1_ax, r1_depth} = r1_side;

  // root = sqrt(slope << F)
  localparam int unsigned SW2 = 97;
  logic           r2_vld;
  logic [RW-1:0]  r2_root;
  logic [SW2-1:0] r2_side;
  logic           r2_zero, r2_pos;
  logic [30:0]    r2_ax;
  logic [31:0]    r2_depth, r2_slope;

  mef_sqrt #(.NW(RIN), .SW(SW2)) u_sqrt_root (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r1_vld),
    .rad_i(RIN'({r1_slope, {FRAC_BITS{1'b0}}})),
    .side_i({r1_zero, r1_pos, r1_ax, r1_depth, r1_slope}),
    .valid_o(r2_vld), .root_o(r2_root), .side_o(r2_side)
  );
  assign {r2_zero, r2_pos, r2_ax, r2_depth, r2_slope} = r2_side;

  // ratio = (ax << F) / slope
  localparam int unsigned SW3 = 34 + RW;
  logic           d_vld;
  logic [QW-1:0]  d_ratio;
  logic [SW3-1:0] d_side;
  logic           d_zero, d_pos;
  logic [31:0]    d_depth;
  logic [RW-1:0]  d_root;

  mef_div #(.NUMW(31 + FRAC_BITS), .QW(QW), .SW(SW3)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r2_vld),
    .num_i({r2_ax, {FRAC_BITS{1'b0}}}), .den_i(r2_slope),
    .side_i({r2_zero, r2_pos, r2_depth, r2_root}),
    .valid_o(d_vld), .quo_o(d_ratio), .side_o(d_side)
  );
  assign {d_zero, d_pos, d_depth, d_root} = d_side;

  // pw = depth^(2/3)
  localparam int unsigned SW4 = 34 + RW + QW;
  logic           c_vld;
  logic [CW-1:0]  c_pw;
  logic [SW4-1:0] c_side;
  logic           c_zero, c_pos;
  logic [31:0]    c_depth;
  logic [RW-1:0]  c_root;
  logic [QW-1:0]  c_ratio;

  mef_cbrt #(.FRAC_BITS(FRAC_BITS), .SW(SW4)) u_cbrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_vld), .depth_i(d_depth),
    .side_i({d_zero, d_pos, d_depth, d_root, d_ratio}),
    .valid_o(c_vld), .pw_o(c_pw), .side_o(c_side)
  );
  assign {c_zero, c_pos, c_depth, c_root, c_ratio} = c_side;

  // vfull = ((root * pw) >> F) * inv_manning >> F
  localparam int unsigned SW5 = 34 + QW;
  logic           m1_vld, m2_vld;
  logic [63:0]    m1_p, m2_p;
  logic [SW5-1:0] m1_side, m2_side;
  logic           m2_zero, m2_pos;
  logic [31:0]    m2_depth;
  logic [QW-1:0]  m2_ratio;

  mef_mulq #(.FRAC_BITS(FRAC_BITS), .SW(SW5)) u_mul_rp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_vld),
    .a_i(64'(c_root)), .b_i(32'(c_pw)),
    .side_i({c_zero, c_pos, c_depth, c_ratio}),
    .valid_o(m1_vld), .p_o(m1_p), .side_o(m1_side)
  );

  mef_mulq #(.FRAC_BITS(FRAC_BITS), .SW(SW5)) u_mul_n (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_vld),
    .a_i(m1_p), .b_i(inv_manning_q), .side_i(m1_side),
    .valid_o(m2_vld), .p_o(m2_p), .side_o(m2_side)
  );
  assign {m2_zero, m2_pos, m2_depth, m2_ratio} = m2_side;

  // magnitude = vfull * depth * cell_size * ratio, each >> F
  localparam int unsigned SW6 = 66 + QW;
  logic           m3_vld, m4_vld, m5_vld;
  logic [63:0]    m3_p, m4_p, m5_p;
  logic [SW6-1:0] m3_side, m4_side;
  logic [65:0]    m5_side;
  logic           m4_zero, m4_pos, m5_zero, m5_pos;
  logic [QW-1:0]  m4_ratio;
  logic [63:0]    m4_vfull, m5_vfull;

  mef_mulq #(.FRAC_BITS(FRAC_BITS), .SW(SW6)) u_mul_d (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m2_vld),
    .a_i(m2_p), .b_i(m2_depth), .side_i({m2_zero, m2_pos, m2_ratio, m2_p}),
    .valid_o(m3_vld), .p_o(m3_p), .side_o(m3_side)
  );

  mef_mulq #(.FRAC_BITS(FRAC_BITS), .SW(SW6)) u_mul_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m3_vld),
    .a_i(m3_p), .b_i(cell_size_q), .side_i(m3_side),
    .valid_o(m4_vld), .p_o(m4_p), .side_o(m4_side)
  );
  assign {m4_zero, m4_pos, m4_ratio, m4_vfull} = m4_side;

  mef_mulq #(.FRAC_BITS(FRAC_BITS), .SW(66)) u_mul_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m4_vld),
    .a_i(m4_p), .b_i(32'(m4_ratio)), .side_i({m4_zero, m4_pos, m4_vfull}),
    .valid_o(m5_vld), .p_o(m5_p), .side_o(m5_side)
  );
  assign {m5_zero, m5_pos, m5_vfull} = m5_side;

  // sign, saturation, dry/level edge
  out_t res;

  always_comb begin
    if (m5_zero) begin
      res.flow  = '0;
      res.speed = '0;
    end else begin
      if (m5_pos) begin
        res.flow = (m5_p > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m5_p[31:0]);
      end else begin
        res.flow = (m5_p > 64'(MAG31)) ? $signed({1'b0, MAG31}) : $signed(m5_p[31:0]);
      end
      res.speed = (m5_vfull > 64'hFFFF_FFFF) ? '1 : m5_vfull[31:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m5_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/mef_front.sv
// Slopes, depth and squared gradient: four stages
module mef_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  mef_pkg::in_t  data_i,
  input  logic [31:0]   inv_cell_size_i,
  output logic          valid_o,
  output logic          zero_o,
  output logic          pos_o,
  output logic [30:0]   ax_o,
  output logic [31:0]   depth_o,
  output logic [62:0]   sumsq_o
);
  import mef_pkg::*;

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    return (x < 0) ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic signed [32:0] side_diff(input kind_e k,
                                                   input logic signed [31:0] c,
                                                   input logic signed [31:0] n,
                                                   input logic signed [31:0] s);
    case (k)
      KIND_NORTH: return 33'(n) - 33'(c);
      KIND_SOUTH: return 33'(c) - 33'(s);
      KIND_BOTH:  return 33'(n) - 33'(s);
      default:    return 33'sd0;
    endcase
  endfunction

  // extra right shift: halved one-sided, quartered central
  function automatic logic [1:0] side_extra(input kind_e k);
    case (k)
      KIND_BOTH: return 2'd2;
      default:   return 2'd1;
    endcase
  endfunction

  function automatic logic [30:0] sat_shr(input logic [63:0] p, input logic [1:0] extra);
    logic [63:0] t;
    t = p >> (FRAC_BITS + 32'(extra));
    return (t > 64'(MAG31)) ? MAG31 : t[30:0];
  endfunction

  // stage 1: differences and scaling products
  logic signed [31:0] hmax, zmax;
  logic signed [32:0] dx, yc, ye;
  logic               s1_vld_q;
  logic [63:0]        s1_pdx_q, s1_pyc_q, s1_pye_q;
  logic               s1_dxneg_q, s1_ycneg_q, s1_yeneg_q;
  logic [1:0]         s1_xc_q, s1_xe_q;
  logic signed [32:0] s1_depth_q;

  always_comb begin
    hmax = (data_i.head_center > data_i.head_east) ? data_i.head_center : data_i.head_east;
    zmax = (data_i.bed_center > data_i.bed_east) ? data_i.bed_center : data_i.bed_east;
    dx   = 33'(data_i.head_east) - 33'(data_i.head_center);
    yc   = side_diff(data_i.kind_center, data_i.head_center,
                     data_i.head_north, data_i.head_south);
    ye   = side_diff(data_i.kind_east, data_i.head_east,
                     data_i.head_north_east, data_i.head_south_east);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pdx_q   <= {32'd0, mag33(dx)} * {32'd0, inv_cell_size_i};
      s1_pyc_q   <= {32'd0, mag33(yc)} * {32'd0, inv_cell_size_i};
      s1_pye_q   <= {32'd0, mag33(ye)} * {32'd0, inv_cell_size_i};
      s1_dxneg_q <= dx[32];
      s1_ycneg_q <= yc[32];
      s1_yeneg_q <= ye[32];
      s1_xc_q    <= side_extra(data_i.kind_center);
      s1_xe_q    <= side_extra(data_i.kind_east);
      s1_depth_q <= 33'(hmax) - 33'(zmax);
    end
  end

  // stage 2: saturate, sum y terms, dry/level test
  logic [30:0]        dxm, ycm, yem;
  logic signed [32:0] tc, te, ysum;
  logic [30:0]        ay;
  logic               s2_vld_q, s2_zero_q, s2_pos_q;
  logic [30:0]        s2_ax_q, s2_ay_q;
  logic [31:0]        s2_depth_q;

  always_comb begin
    dxm  = sat_shr(s1_pdx_q, 2'd0);
    ycm  = sat_shr(s1_pyc_q, s1_xc_q);
    yem  = sat_shr(s1_pye_q, s1_xe_q);
    tc   = s1_ycneg_q ? -$signed(33'(ycm)) : $signed(33'(ycm));
    te   = s1_yeneg_q ? -$signed(33'(yem)) : $signed(33'(yem));
    ysum = tc + te;
    if (ysum > $signed(33'(MAG31))) begin
      ay = MAG31;
    end else if (ysum < -$signed(33'(MAG31))) begin
      ay = MAG31;
    end else begin
      ay = (ysum < 0) ? 31'(-ysum) : 31'(ysum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_zero_q  <= (s1_depth_q <= 33'sd0) || (dxm == 31'd0);
      s2_pos_q   <= !s1_dxneg_q;
      s2_ax_q    <= dxm;
      s2_ay_q    <= ay;
      s2_depth_q <= s1_depth_q[31:0];
    end
  end

  // stage 3: squares
  logic        s3_vld_q, s3_zero_q, s3_pos_q;
  logic [30:0] s3_ax_q;
  logic [31:0] s3_depth_q;
  logic [61:0] s3_sqx_q, s3_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_zero_q  <= s2_zero_q;
      s3_pos_q   <= s2_pos_q;
      s3_ax_q    <= s2_ax_q;
      s3_depth_q <= s2_depth_q;
      s3_sqx_q   <= {31'd0, s2_ax_q} * {31'd0, s2_ay_q & 31'd0 | s2_ax_q};
      s3_sqy_q   <= {31'd0, s2_ay_q} * {31'd0, s2_ay_q};
    end
  end

  // stage 4: sum of squares
  logic        s4_vld_q, s4_zero_q, s4_pos_q;
  logic [30:0] s4_ax_q;
  logic [31:0] s4_depth_q;
  logic [62:0] s4_ss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_zero_q  <= s3_zero_q;
      s4_pos_q   <= s3_pos_q;
      s4_ax_q    <= s3_ax_q;
      s4_depth_q <= s3_depth_q;
      s4_ss_q    <= 63'(s3_sqx_q) + 63'(s3_sqy_q);
    end
  end

  assign valid_o = s4_vld_q;
  assign zero_o  = s4_zero_q;
  assign pos_o   = s4_pos_q;
  assign ax_o    = s4_ax_q;
  assign depth_o = s4_depth_q;
  assign sumsq_o = s4_ss_q;

endmodule

FILE: rtl/mef_sqrt.sv
// Pipelined integer square root, one result bit per stage
module mef_sqrt #(
  parameter int unsigned NW = 64,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NW-1:0]       rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [NW/2-1:0]     root_o,
  output logic [SW-1:0]       side_o
);
  localparam int unsigned RW   = NW / 2;
  localparam int unsigned REMW = RW + 2;

  logic [NW-1:0]   val_q [RW];
  logic [REMW-1:0] rem_q [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SW-1:0]   side_q [RW];
  logic            vld_q [RW];

  logic [NW-1:0]   val_s [RW+1];
  logic [REMW-1:0] rem_s [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [SW-1:0]   side_s [RW+1];
  logic            vld_s [RW+1];

  logic [NW-1:0]   val_d [RW];
  logic [REMW-1:0] rem_d [RW];
  logic [RW-1:0]   root_d [RW];

  // stage inputs: port for the first, previous register after
  always_comb begin
    val_s[0]  = rad_i;
    rem_s[0]  = '0;
    root_s[0] = '0;
    side_s[0] = side_i;
    vld_s[0]  = valid_i;
    for (int i = 1; i <= RW; i++) begin
      val_s[i]  = val_q[i-1];
      rem_s[i]  = rem_q[i-1];
      root_s[i] = root_q[i-1];
      side_s[i] = side_q[i-1];
      vld_s[i]  = vld_q[i-1];
    end
  end

  // restoring step: bring down two bits, try root*4+1
  always_comb begin
    logic [REMW-1:0] remsh;
    logic [REMW-1:0] trial;
    for (int i = 0; i < RW; i++) begin
      remsh      = {rem_s[i][REMW-3:0], val_s[i][NW-1:NW-2]};
      trial      = {root_s[i], 2'b01};
      val_d[i]   = val_s[i] << 2;
      if (remsh >= trial) begin
        rem_d[i]  = remsh - trial;
        root_d[i] = {root_s[i][RW-2:0], 1'b1};
      end else begin
        rem_d[i]  = remsh;
        root_d[i] = {root_s[i][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      for (int i = 0; i < RW; i++) begin
        vld_q[i] <= vld_s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RW; i++) begin
        val_q[i]  <= val_d[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        side_q[i] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[RW];
  assign root_o  = root_s[RW];
  assign side_o  = side_s[RW];

endmodule

FILE: rtl/mef_div.sv
// Pipelined restoring divider, one quotient bit per stage
module mef_div #(
  parameter int unsigned NUMW = 47,
  parameter int unsigned QW   = 17,
  parameter int unsigned SW   = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [31:0]     den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o,
  output logic [SW-1:0]   side_o
);
  logic [32:0]   rem_q [QW];
  logic [QW-1:0] lo_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [31:0]   den_q [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q [QW];

  logic [32:0]   rem_s [QW+1];
  logic [QW-1:0] lo_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [31:0]   den_s [QW+1];
  logic [SW-1:0] side_s [QW+1];
  logic          vld_s [QW+1];

  logic [32:0]   rem_d [QW];
  logic [QW-1:0] quo_d [QW];

  // upper dividend bits start as the partial remainder
  always_comb begin
    rem_s[0]  = 33'(num_i >> QW);
    lo_s[0]   = num_i[QW-1:0];
    quo_s[0]  = '0;
    den_s[0]  = den_i;
    side_s[0] = side_i;
    vld_s[0]  = valid_i;
    for (int i = 1; i <= QW; i++) begin
      rem_s[i]  = rem_q[i-1];
      lo_s[i]   = lo_q[i-1];
      quo_s[i]  = quo_q[i-1];
      den_s[i]  = den_q[i-1];
      side_s[i] = side_q[i-1];
      vld_s[i]  = vld_q[i-1];
    end
  end

  always_comb begin
    logic [32:0] remsh;
    for (int i = 0; i < QW; i++) begin
      remsh = {rem_s[i][31:0], lo_s[i][QW-1]};
      if (remsh >= {1'b0, den_s[i]}) begin
        rem_d[i] = remsh - {1'b0, den_s[i]};
        quo_d[i] = {quo_s[i][QW-2:0], 1'b1};
      end else begin
        rem_d[i] = remsh;
        quo_d[i] = {quo_s[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        vld_q[i] <= vld_s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_d[i];
        lo_q[i]   <= lo_s[i] << 1;
        quo_q[i]  <= quo_d[i];
        den_q[i]  <= den_s[i];
        side_q[i] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[QW];
  assign quo_o   = quo_s[QW];
  assign side_o  = side_s[QW];

endmodule

FILE: rtl/mef_cbrt.sv
// floor(cbrt(d^2 << FRAC_BITS)): square stage, then one root bit per stage
module mef_cbrt #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SW        = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [31:0]                     depth_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            valid_o,
  output logic [(64+FRAC_BITS+2)/3-1:0]   pw_o,
  output logic [SW-1:0]                   side_o
);
  localparam int unsigned NBW = 64 + FRAC_BITS;
  localparam int unsigned CW  = (NBW + 2) / 3;
  localparam int unsigned CUW = 3 * CW;
  localparam int unsigned AW  = CUW + 2;

  // square stage
  logic           sq_vld_q;
  logic [NBW-1:0] sq_n_q;
  logic [SW-1:0]  sq_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_n_q    <= NBW'({32'd0, depth_i} * {32'd0, depth_i}) << FRAC_BITS;
      sq_side_q <= side_i;
    end
  end

  logic [NBW-1:0]  n_q [CW];
  logic [CW-1:0]   y_q [CW];
  logic [2*CW-1:0] y2_q [CW];
  logic [CUW-1:0]  y3_q [CW];
  logic [SW-1:0]   side_q [CW];
  logic            vld_q [CW];

  logic [NBW-1:0]  n_s [CW+1];
  logic [CW-1:0]   y_s [CW+1];
  logic [2*CW-1:0] y2_s [CW+1];
  logic [CUW-1:0]  y3_s [CW+1];
  logic [SW-1:0]   side_s [CW+1];
  logic            vld_s [CW+1];

  logic [CW-1:0]   y_d [CW];
  logic [2*CW-1:0] y2_d [CW];
  logic [CUW-1:0]  y3_d [CW];

  always_comb begin
    n_s[0]    = sq_n_q;
    y_s[0]    = '0;
    y2_s[0]   = '0;
    y3_s[0]   = '0;
    side_s[0] = sq_side_q;
    vld_s[0]  = sq_vld_q;
    for (int i = 1; i <= CW; i++) begin
      n_s[i]    = n_q[i-1];
      y_s[i]    = y_q[i-1];
      y2_s[i]   = y2_q[i-1];
      y3_s[i]   = y3_q[i-1];
      side_s[i] = side_q[i-1];
      vld_s[i]  = vld_q[i-1];
    end
  end

  // (y+b)^3 = y^3 + 3y^2 b + 3y b^2 + b^3, with b = 2^k
  always_comb begin
    logic [AW-1:0] sq3;
    logic [AW-1:0] y3x;
    logic [AW-1:0] cand;
    int            k;
    for (int i = 0; i < CW; i++) begin
      k    = CW - 1 - i;
      sq3  = AW'(y2_s[i]) + (AW'(y2_s[i]) << 1);
      y3x  = AW'(y_s[i]) + (AW'(y_s[i]) << 1);
      cand = AW'(y3_s[i]) + (sq3 << k) + (y3x << (2 * k)) + (AW'(1) << (3 * k));
      if (cand <= AW'(n_s[i])) begin
        y_d[i]  = y_s[i] | (CW'(1) << k);
        y2_d[i] = y2_s[i] + ((2*CW)'(y_s[i]) << (k + 1)) + ((2*CW)'(1) << (2 * k));
        y3_d[i] = cand[CUW-1:0];
      end else begin
        y_d[i]  = y_s[i];
        y2_d[i] = y2_s[i];
        y3_d[i] = y3_s[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CW; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      for (int i = 0; i < CW; i++) begin
        vld_q[i] <= vld_s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CW; i++) begin
        n_q[i]    <= n_s[i];
        y_q[i]    <= y_d[i];
        y2_q[i]   <= y2_d[i];
        y3_q[i]   <= y3_d[i];
        side_q[i] <= side_s[i];
      end
    end
  end

  assign valid_o = vld_s[CW];
  assign pw_o    = y_s[CW];
  assign side_o  = side_s[CW];

endmodule

FILE: rtl/mef_mulq.sv
// (a * b) >> FRAC_BITS saturated at 2^64-1: partial products, then combine
module mef_mulq #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SW        = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   a_i,
  input  logic [31:0]   b_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [63:0]   p_o,
  output logic [SW-1:0] side_o
);
  logic          pp_vld_q;
  logic [63:0]   pp_lo_q, pp_hi_q;
  logic [SW-1:0] pp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else if (en_i) begin
      pp_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q   <= {32'd0, a_i[31:0]} * {32'd0, b_i};
      pp_hi_q   <= {32'd0, a_i[63:32]} * {32'd0, b_i};
      pp_side_q <= side_i;
    end
  end

  // combine, scale, saturate
  logic [95:0] full, scaled;
  logic [63:0] p_d;

  always_comb begin
    full   = {pp_hi_q, 32'd0} + {32'd0, pp_lo_q};
    scaled = full >> FRAC_BITS;
    p_d    = (scaled[95:64] != 32'd0) ? '1 : scaled[63:0];
  end

  logic          vld_q;
  logic [63:0]   p_q;
  logic [SW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= pp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      side_q <= pp_side_q;
    end
  end

  assign valid_o = vld_q;
  assign p_o     = p_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/mef_check.sv
// Port-level checks for the edge flux core
module mef_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input mef_pkg::out_t out_data_o
);
  import mef_pkg::*;

  // no result shows while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // no speed means no discharge
  a_still_dry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.speed == 32'd0)) |-> (out_data_o.flow == 32'sd0))
    else $error("flow without speed");

endmodule

bind manning_edge_flux_core mef_check u_check (.*);

FILE: tb/manning_edge_flux_core_tb.sv
`timescale 1ns / 100ps

module manning_edge_flux_core_tb;
  import mef_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned DRAIN_CYCLES = 130;     // pipeline latency plus margin
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  manning_edge_flux_core #(.FRAC_BITS(FRAC)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Clock: 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copies of the registers
  logic [31:0] cell_size_q;
  logic [31:0] inv_cell_size_q;
  logic [31:0] inv_manning_q;

  out_t flux_expected[$];
  int err_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;

  // ---------------- Flux predictor ----------------

  function automatic logic [63:0] isqrt_u64(input logic [63:0] n);
    logic [63:0] rem, root, bitv;
    rem = n;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(cbrt(d*d << FRAC))
  function automatic logic [63:0] depth_pow23(input logic [63:0] d);
    logic [127:0] target, t, cube;
    logic [63:0] y;
    target = ({64'd0, d} * {64'd0, d}) << FRAC;
    y = '0;
    for (int i = 30; i >= 0; i--) begin
      t = {64'd0, y | (64'd1 << i)};
      cube = t * t * t;
      if (cube <= target) y = t[63:0];
    end
    return y;
  endfunction

  // (a*b) >> FRAC, saturated at 2^64-1
  function automatic logic [63:0] mul_frac(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> FRAC;
    return (prod[127:64] != 0) ? '1 : prod[63:0];
  endfunction

  // Difference scaled by the inverse cell size, sign-magnitude, 31-bit cap
  function automatic longint scaled_diff(input longint diff, input int shift);
    logic [63:0] mag;
    logic neg;
    neg = diff < 0;
    mag = neg ? -diff : diff;
    mag = (mag * {32'd0, inv_cell_size_q}) >> shift;
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint y_term(input kind_e kind, input longint c,
                                    input longint n, input longint s);
    case (kind)
      KIND_NORTH: return scaled_diff(n - c, FRAC + 1);
      KIND_SOUTH: return scaled_diff(c - s, FRAC + 1);
      KIND_BOTH:  return scaled_diff(n - s, FRAC + 2);
      default:    return 0;
    endcase
  endfunction

  function automatic out_t predict_flux(input in_t e);
    out_t res;
    longint hc, he, depth, dhdx, dhdy;
    logic [63:0] ax, ay, slope, root, pw, vfull, ratio, mag;
    hc = longint'(e.head_center);
    he = longint'(e.head_east);
    depth = (hc > he ? hc : he) -
            (longint'(e.bed_center) > longint'(e.bed_east) ?
             longint'(e.bed_center) : longint'(e.bed_east));
    dhdx = scaled_diff(he - hc, FRAC);
    res.flow = '0;
    res.speed = '0;
    if (depth <= 0 || dhdx == 0) return res;
    dhdy = y_term(e.kind_center, hc, e.head_north, e.head_south) +
           y_term(e.kind_east, he, e.head_north_east, e.head_south_east);
    if (dhdy > 64'sh7FFF_FFFF) dhdy = 64'sh7FFF_FFFF;
    if (dhdy < -64'sh7FFF_FFFF) dhdy = -64'sh7FFF_FFFF;
    ax = dhdx < 0 ? -dhdx : dhdx;
    ay = dhdy < 0 ? -dhdy : dhdy;
    slope = isqrt_u64(ax * ax + ay * ay);
    root = isqrt_u64(slope << FRAC);
    pw = depth_pow23(depth);
    vfull = mul_frac(mul_frac(root, pw), {32'd0, inv_manning_q});
    ratio = (ax << FRAC) / slope;
    mag = mul_frac(vfull, depth);
    mag = mul_frac(mag, {32'd0, cell_size_q});
    mag = mul_frac(mag, ratio);
    if (dhdx > 0) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      res.flow = -mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      res.flow = mag[31:0];
    end
    res.speed = (vfull > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vfull[31:0];
    return res;
  endfunction

  // ---------------- Driving ----------------

  task automatic send_edge(input in_t e);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    flux_expected.push_back(predict_flux(e));
  endtask

  // Enable drops for one cycle so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CELL_SIZE:     cell_size_q = val;
      CFG_INV_CELL_SIZE: inv_cell_size_q = val;
      CFG_INV_MANNING:   inv_manning_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Stop offering and let the pipeline empty out
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (flux_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(4))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'h0000_8000 + $urandom_range(32'h0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] near(input logic [31:0] base, input int span);
    return base + $urandom_range(2 * span) - span;
  endfunction

  // Mostly wet edges with small slopes; some fully random ones
  function automatic in_t rand_edge();
    in_t e;
    logic [31:0] base, lo;
    if ($urandom_range(4) == 0) begin
      e = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, 4'($urandom)};
      return e;
    end
    base = $urandom_range(32'h0200_0000) - 32'h0100_0000;
    e.head_center = near(base, 32'h0004_0000);
    e.head_east = ($urandom_range(9) == 0) ? e.head_center : near(base, 32'h0004_0000);
    lo = (e.head_center < e.head_east) ? e.head_center : e.head_east;
    e.bed_center = lo - $urandom_range(32'h0008_0000) + 32'h0000_8000;
    e.bed_east = lo - $urandom_range(32'h0008_0000) + 32'h0000_8000;
    e.head_north = near(base, 32'h0008_0000);
    e.head_south = near(base, 32'h0008_0000);
    e.head_north_east = near(base, 32'h0008_0000);
    e.head_south_east = near(base, 32'h0008_0000);
    e.kind_center = kind_e'($urandom_range(3));
    e.kind_east = kind_e'($urandom_range(3));
    return e;
  endfunction

  function automatic in_t make_edge(input logic [31:0] hc, he, zc, ze, hn, hs, hne, hse,
                                    input kind_e kc, ke);
    in_t e;
    e = {hc, he, zc, ze, hn, hs, hne, hse, kc, ke};
    return e;
  endfunction

  // ---------------- Receiver and checker ----------------

  int hold_seen;
  int hold_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen <= 0;
      hold_cnt <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (flux_expected.size() == 0) begin
        report_mismatch("unexpected transfer, flow", out_data_o.flow, '0);
      end else begin
        want = flux_expected.pop_front();
        if (out_data_o.flow !== want.flow)
          report_mismatch("flow", out_data_o.flow, want.flow);
        if (out_data_o.speed !== want.speed)
          report_mismatch("speed", out_data_o.speed, want.speed);
      end
    end
  end

  // ---------------- Tests ----------------

  task automatic test_directed();
    // extremes of the heads and beds
    send_edge(make_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        KIND_BOTH, KIND_BOTH));
    send_edge(make_edge(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        KIND_NORTH, KIND_SOUTH));
    send_edge(make_edge('0, '0, '0, '0, '0, '0, '0, '0, KIND_NONE, KIND_NONE));
    send_edge(make_edge('1, '1, '1, '1, '1, '1, '1, '1, KIND_BOTH, KIND_BOTH));
    // dry edge: center bed above both heads
    send_edge(make_edge(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000,
                        '0, '0, '0, '0, KIND_BOTH, KIND_NONE));
    // level edge
    send_edge(make_edge(32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0009_0000, '0, '0, 32'h0009_0000, KIND_BOTH, KIND_BOTH));
    // every pair of kind codes, wet sloped edge with big side differences
    for (int k = 0; k < 16; k++)
      send_edge(make_edge(32'h0003_0000, 32'h0002_8000 + k, 32'h0001_0000, 32'h0000_8000,
                          32'h0013_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0007_0000,
                          kind_e'(k >> 2), kind_e'(k & 3)));
    drain_pipe();
  endtask

  task automatic test_register_extremes();
    logic [31:0] vals[3];
    vals = '{32'd0, 32'hFFFF_FFFF, 32'd1};
    foreach (vals[i]) begin
      write_reg(CFG_CELL_SIZE, vals[i]);
      write_reg(CFG_INV_CELL_SIZE, vals[(i + 1) % 3]);
      write_reg(CFG_INV_MANNING, vals[(i + 2) % 3]);
      write_reg(CFG_IDX_UNUSED, $urandom);
      for (int n = 0; n < 8; n++) send_edge(rand_edge());
      drain_pipe();
    end
    write_reg(CFG_CELL_SIZE, 32'h0001_0000);
    write_reg(CFG_INV_CELL_SIZE, 32'h0001_0000);
    write_reg(CFG_INV_MANNING, 32'h0021_0000);
  endtask

  task automatic test_random_phase(input int count, input int idle_pct,
                                   input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) send_edge(rand_edge());
    drain_pipe();
    write_reg(CFG_CELL_SIZE, rand_reg());
    write_reg(CFG_INV_CELL_SIZE, rand_reg());
    write_reg(CFG_INV_MANNING, rand_reg());
  endtask

  // Receiver holds off long while the sender keeps offering: pipeline fills up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int n = 0; n < 200; n++) send_edge(rand_edge());
    drain_pipe();
  endtask

  initial begin
    cell_size_q = 32'h0001_0000;
    inv_cell_size_q = 32'h0001_0000;
    inv_manning_q = 32'h0021_0000;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_CELL_SIZE;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_phase(90, 0, 0);
    test_random_phase(90, 83, 0);
    test_random_phase(90, 0, 83);
    test_random_phase(90, 18, 18);
    test_backpressure();

    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mef_pkg.sv
rtl/mef_front.sv
rtl/mef_sqrt.sv
rtl/mef_div.sv
rtl/mef_cbrt.sv
rtl/mef_mulq.sv
rtl/manning_edge_flux_core.sv
rtl/mef_check.sv
tb/manning_edge_flux_core_tb.sv
